### design/wodo_pkg.sv
// Shared types, constants and microcode word layout for the wheel odometry block.
`default_nettype none

package wodo_pkg;

  // Field and datapath widths
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned MA_W     = 33;
  localparam int unsigned MB_W     = 17;
  localparam int unsigned PROD_W   = MA_W + MB_W;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned SCALED_W = 49;
  localparam int unsigned PC_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Program length, addresses 0 .. PROG_LEN-1 are in use
  localparam logic [PC_W-1:0] PROG_LEN = 6'd39;

  // Q0.16 filter coefficients and the shift that lines a distance up with Q.40 products
  localparam logic [MB_W-1:0] COEF_NEW   = 17'd6554;
  localparam logic [MB_W-1:0] COEF_OLD   = 17'd58982;
  localparam logic [MB_W-1:0] DIST_ALIGN = 17'd256;

  // Register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd65536;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd3277;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd83886;

  // Saturation limits of a Q16.16 word
  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Item opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_GAIN     = 2'd0,
    CFG_WHEEL_RADIUS   = 2'd1,
    CFG_CONTROL_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Multiplier operand A (33 bit signed)
  typedef enum logic [3:0] {
    A_GAIN,
    A_S_HI,
    A_S_LO,
    A_RATE_L,
    A_RATE_R,
    A_SPD_L,
    A_SPD_R,
    A_DIST_L,
    A_DIST_R
  } a_sel_t;

  // Multiplier operand B (17 bit signed)
  typedef enum logic [2:0] {
    B_TICK_L,
    B_TICK_R,
    B_COEF_NEW,
    B_COEF_OLD,
    B_RADIUS,
    B_PER_LO,
    B_PER_HI,
    B_DIST_ALIGN
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SCALED,
    WB_RATE_L,
    WB_RATE_R,
    WB_SPD_L,
    WB_SPD_R,
    WB_DIST_L,
    WB_DIST_R,
    WB_CLR_DIST
  } wb_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BR_CLEAR,
    SEQ_DONE
  } seq_op_t;

  // One control word of the microprogram
  typedef struct packed {
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    logic            mul_en;
    acc_op_t         acc_op;
    logic            acc_sh16;
    wb_t             wb;
    logic            rnd24;
    seq_op_t         seq;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    uword_t uw;
    logic   exec;
    logic   emit;
  } ctl_t;

  // Sequencer status
  typedef struct packed {
    logic            running;
    logic [PC_W-1:0] pc;
  } seq_status_t;

endpackage

`default_nettype wire

### design/wodo_if.sv
// Channel interfaces: input word, result word and register write.
`default_nettype none

interface wodo_in_if;
  import wodo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [TICK_W-1:0] left_ticks;
  logic signed [TICK_W-1:0] right_ticks;

  modport source (output valid, output opcode, output left_ticks, output right_ticks,
                  input ready);
  modport sink   (input valid, input opcode, input left_ticks, input right_ticks,
                  output ready);
endinterface

interface wodo_out_if;
  import wodo_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] left_speed;
  logic signed [Q_W-1:0] right_speed;
  logic signed [Q_W-1:0] total_distance;
  logic signed [Q_W-1:0] delta_distance;

  modport source (output valid, output left_speed, output right_speed,
                  output total_distance, output delta_distance, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input total_distance, input delta_distance, output ready);
endinterface

interface wodo_cfg_if;
  import wodo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/wodo_ucode_rom.sv
// Microprogram store: one control word per step address.
`default_nettype none

module wodo_ucode_rom (
  input  wire logic [wodo_pkg::PC_W-1:0] pc,
  output wodo_pkg::uword_t               word
);
  import wodo_pkg::*;

  localparam logic [PC_W-1:0] L_CLEAR = 6'd31;
  localparam logic [PC_W-1:0] NO_TGT  = 6'd0;

  function automatic uword_t uw(a_sel_t a, b_sel_t b, logic m, acc_op_t op, logic s16,
                                wb_t w, logic r24, seq_op_t q, logic [PC_W-1:0] t);
    uword_t u;
    u.a_sel    = a;
    u.b_sel    = b;
    u.mul_en   = m;
    u.acc_op   = op;
    u.acc_sh16 = s16;
    u.wb       = w;
    u.rnd24    = r24;
    u.seq      = q;
    u.target   = t;
    return u;
  endfunction

  // Per wheel: scaled = gain*ticks, rate filter, speed, distance with Q.24 step
  always_comb begin
    case (pc)
      // left wheel; clear items branch off at once
      6'd0:  word = uw(A_GAIN,   B_TICK_L,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_BR_CLEAR, L_CLEAR);
      6'd1:  word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_SCALED, 1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd2:  word = uw(A_S_HI,   B_COEF_NEW,   1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd3:  word = uw(A_S_LO,   B_COEF_NEW,   1'b1, ACC_LOAD, 1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd4:  word = uw(A_RATE_L, B_COEF_OLD,   1'b1, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd5:  word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd6:  word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_RATE_L, 1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd7:  word = uw(A_RATE_L, B_RADIUS,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd8:  word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_LOAD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd9:  word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_SPD_L,  1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd10: word = uw(A_DIST_L, B_DIST_ALIGN, 1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd11: word = uw(A_SPD_L,  B_PER_LO,     1'b1, ACC_LOAD, 1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd12: word = uw(A_SPD_L,  B_PER_HI,     1'b1, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd13: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_ADD,  1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd14: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_DIST_L, 1'b1,
                       SEQ_NEXT, NO_TGT);
      // right wheel
      6'd15: word = uw(A_GAIN,   B_TICK_R,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd16: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_HOLD, 1'b0, WB_SCALED, 1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd17: word = uw(A_S_HI,   B_COEF_NEW,   1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd18: word = uw(A_S_LO,   B_COEF_NEW,   1'b1, ACC_LOAD, 1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd19: word = uw(A_RATE_R, B_COEF_OLD,   1'b1, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd20: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd21: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_HOLD, 1'b0, WB_RATE_R, 1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd22: word = uw(A_RATE_R, B_RADIUS,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd23: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_LOAD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd24: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_HOLD, 1'b0, WB_SPD_R,  1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd25: word = uw(A_DIST_R, B_DIST_ALIGN, 1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd26: word = uw(A_SPD_R,  B_PER_LO,     1'b1, ACC_LOAD, 1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd27: word = uw(A_SPD_R,  B_PER_HI,     1'b1, ACC_ADD,  1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd28: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_ADD,  1'b1, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd29: word = uw(A_GAIN,   B_TICK_R,     1'b0, ACC_HOLD, 1'b0, WB_DIST_R, 1'b1,
                       SEQ_NEXT, NO_TGT);
      6'd30: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_DONE, NO_TGT);
      // clear: speeds from present rates, then zero both distances
      6'd31: word = uw(A_RATE_L, B_RADIUS,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd32: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_LOAD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd33: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_SPD_L,  1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd34: word = uw(A_RATE_R, B_RADIUS,     1'b1, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd35: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_LOAD, 1'b0, WB_NONE,   1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd36: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_SPD_R,  1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd37: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_CLR_DIST, 1'b0,
                       SEQ_NEXT, NO_TGT);
      6'd38: word = uw(A_GAIN,   B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                       SEQ_DONE, NO_TGT);
      default: word = uw(A_GAIN, B_TICK_L,     1'b0, ACC_HOLD, 1'b0, WB_NONE,   1'b0,
                         SEQ_DONE, NO_TGT);
    endcase
  end

endmodule

`default_nettype wire

### design/wodo_seq.sv
// Step counter and branch logic that walks the microprogram for one word at a time.
`default_nettype none

module wodo_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_accept,
  input  wire logic                      in_opcode,
  input  wire logic                      out_free,
  input  wodo_pkg::uword_t               uw,
  output logic [wodo_pkg::PC_W-1:0]      pc,
  output logic                           in_ready,
  output wodo_pkg::ctl_t                 ctl,
  output wodo_pkg::seq_status_t          status
);
  import wodo_pkg::*;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            clr_r, clr_nxt;
  logic            done_step;

  assign done_step = (uw.seq == SEQ_DONE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (done_step && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Step address and latched opcode
  always_comb begin
    pc_nxt  = pc_r;
    clr_nxt = clr_r;
    if (in_accept) begin
      pc_nxt  = '0;
      clr_nxt = (in_opcode == OP_CLEAR);
    end else if (state_r == ST_RUN) begin
      case (uw.seq)
        SEQ_NEXT:     pc_nxt = pc_r + 1'b1;
        SEQ_BR_CLEAR: pc_nxt = clr_r ? uw.target : pc_r + 1'b1;
        SEQ_DONE:     pc_nxt = pc_r;
        default:      pc_nxt = pc_r;
      endcase
    end
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    ctl.uw         = uw;
    ctl.exec       = 1'b0;
    ctl.emit       = 1'b0;
    status.running = 1'b0;
    status.pc      = pc_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        ctl.exec       = 1'b1;
        ctl.emit       = done_step && out_free;
        status.running = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign pc = pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

### design/wodo_dp.sv
// Datapath: config registers, one 33x17 multiplier, 64-bit accumulator, state and result word.
`default_nettype none

module wodo_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wodo_pkg::ctl_t                        ctl,
  input  wire logic                             in_accept,
  input  wire logic signed [wodo_pkg::TICK_W-1:0] in_left_ticks,
  input  wire logic signed [wodo_pkg::TICK_W-1:0] in_right_ticks,
  input  wire logic                             cfg_write,
  input  wire logic [wodo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wodo_pkg::GAIN_W-1:0]      cfg_data,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic signed [wodo_pkg::Q_W-1:0]       out_left_speed,
  output logic signed [wodo_pkg::Q_W-1:0]       out_right_speed,
  output logic signed [wodo_pkg::Q_W-1:0]       out_total_distance,
  output logic signed [wodo_pkg::Q_W-1:0]       out_delta_distance,
  output logic                                  out_free
);
  import wodo_pkg::*;

  // Configuration
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;

  // Item operands and working registers
  logic signed [TICK_W-1:0]   tick_l_r, tick_l_nxt, tick_r_r, tick_r_nxt;
  logic signed [SCALED_W-1:0] scaled_r, scaled_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;

  // Filter and odometry state
  logic signed [Q_W-1:0] rate_l_r, rate_l_nxt, rate_r_r, rate_r_nxt;
  logic signed [Q_W-1:0] spd_l_r, spd_l_nxt, spd_r_r, spd_r_nxt;
  logic signed [Q_W-1:0] dist_l_r, dist_l_nxt, dist_r_r, dist_r_nxt;

  // Result word
  logic                  ovalid_r, ovalid_nxt;
  logic signed [Q_W-1:0] o_lspd_r, o_lspd_nxt, o_rspd_r, o_rspd_nxt;
  logic signed [Q_W-1:0] o_tot_r, o_tot_nxt, o_del_r, o_del_nxt;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] prod_ext, prod_sh;
  logic signed [ACC_W-1:0] rnd_sum, rnd_sh;
  logic                    rnd_fits;
  logic signed [Q_W-1:0]   wb_val;
  logic signed [Q_W:0]     dist_sum, dist_dif;

  // Operand A select
  always_comb begin
    case (ctl.uw.a_sel)
      A_GAIN:   mul_a = $signed({1'b0, gain_r});
      A_S_HI:   mul_a = scaled_r[SCALED_W-1:SCALED_W-MA_W];
      A_S_LO:   mul_a = $signed({{(MA_W-16){1'b0}}, scaled_r[15:0]});
      A_RATE_L: mul_a = $signed({rate_l_r[Q_W-1], rate_l_r});
      A_RATE_R: mul_a = $signed({rate_r_r[Q_W-1], rate_r_r});
      A_SPD_L:  mul_a = $signed({spd_l_r[Q_W-1], spd_l_r});
      A_SPD_R:  mul_a = $signed({spd_r_r[Q_W-1], spd_r_r});
      A_DIST_L: mul_a = $signed({dist_l_r[Q_W-1], dist_l_r});
      A_DIST_R: mul_a = $signed({dist_r_r[Q_W-1], dist_r_r});
      default:  mul_a = '0;
    endcase
  end

  // Operand B select; the period splits into a 16-bit low and an 8-bit high part
  always_comb begin
    case (ctl.uw.b_sel)
      B_TICK_L:     mul_b = $signed({tick_l_r[TICK_W-1], tick_l_r});
      B_TICK_R:     mul_b = $signed({tick_r_r[TICK_W-1], tick_r_r});
      B_COEF_NEW:   mul_b = $signed(COEF_NEW);
      B_COEF_OLD:   mul_b = $signed(COEF_OLD);
      B_RADIUS:     mul_b = $signed({1'b0, radius_r});
      B_PER_LO:     mul_b = $signed({1'b0, period_r[15:0]});
      B_PER_HI:     mul_b = $signed({{(MB_W-(PERIOD_W-16)){1'b0}}, period_r[PERIOD_W-1:16]});
      B_DIST_ALIGN: mul_b = $signed(DIST_ALIGN);
      default:      mul_b = '0;
    endcase
  end

  // Product alignment for the accumulator
  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign prod_sh  = ctl.uw.acc_sh16 ? (prod_ext <<< 16) : prod_ext;

  // Round half up, shift by 16 or 24, saturate to Q16.16
  assign rnd_sum  = acc_r + (ctl.uw.rnd24 ? (ACC_W'(1) <<< 23) : (ACC_W'(1) <<< 15));
  assign rnd_sh   = ctl.uw.rnd24 ? (rnd_sum >>> 24) : (rnd_sum >>> 16);
  assign rnd_fits = (rnd_sh[ACC_W-1:Q_W-1] == '0) || (rnd_sh[ACC_W-1:Q_W-1] == '1);
  assign wb_val   = rnd_fits ? rnd_sh[Q_W-1:0] : (rnd_sh[ACC_W-1] ? Q_MIN : Q_MAX);

  // Mean and half difference, floor halving
  assign dist_sum = {dist_l_r[Q_W-1], dist_l_r} + {dist_r_r[Q_W-1], dist_r_r};
  assign dist_dif = {dist_l_r[Q_W-1], dist_l_r} - {dist_r_r[Q_W-1], dist_r_r};

  assign out_free = !ovalid_r || out_ready;

  // Next values
  always_comb begin
    gain_nxt   = gain_r;
    radius_nxt = radius_r;
    period_nxt = period_r;
    tick_l_nxt = tick_l_r;
    tick_r_nxt = tick_r_r;
    scaled_nxt = scaled_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    rate_l_nxt = rate_l_r;
    rate_r_nxt = rate_r_r;
    spd_l_nxt  = spd_l_r;
    spd_r_nxt  = spd_r_r;
    dist_l_nxt = dist_l_r;
    dist_r_nxt = dist_r_r;
    ovalid_nxt = ovalid_r;
    o_lspd_nxt = o_lspd_r;
    o_rspd_nxt = o_rspd_r;
    o_tot_nxt  = o_tot_r;
    o_del_nxt  = o_del_r;

    // register writes; unknown index is dropped
    if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED_GAIN:     gain_nxt   = cfg_data;
        CFG_WHEEL_RADIUS:   radius_nxt = cfg_data[RADIUS_W-1:0];
        CFG_CONTROL_PERIOD: period_nxt = cfg_data[PERIOD_W-1:0];
        default:            gain_nxt   = gain_r;
      endcase
    end

    if (in_accept) begin
      tick_l_nxt = in_left_ticks;
      tick_r_nxt = in_right_ticks;
    end

    if (ctl.exec) begin
      if (ctl.uw.mul_en) prod_nxt = mul_a * mul_b;

      case (ctl.uw.acc_op)
        ACC_HOLD: acc_nxt = acc_r;
        ACC_LOAD: acc_nxt = prod_sh;
        ACC_ADD:  acc_nxt = acc_r + prod_sh;
        default:  acc_nxt = acc_r;
      endcase

      case (ctl.uw.wb)
        WB_NONE:     scaled_nxt = scaled_r;
        WB_SCALED:   scaled_nxt = prod_r[SCALED_W-1:0];
        WB_RATE_L:   rate_l_nxt = wb_val;
        WB_RATE_R:   rate_r_nxt = wb_val;
        WB_SPD_L:    spd_l_nxt  = wb_val;
        WB_SPD_R:    spd_r_nxt  = wb_val;
        WB_DIST_L:   dist_l_nxt = wb_val;
        WB_DIST_R:   dist_r_nxt = wb_val;
        WB_CLR_DIST: begin
          dist_l_nxt = '0;
          dist_r_nxt = '0;
        end
        default:     scaled_nxt = scaled_r;
      endcase
    end

    // result word handshake
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    if (ctl.emit) begin
      ovalid_nxt = 1'b1;
      o_lspd_nxt = spd_l_r;
      o_rspd_nxt = spd_r_r;
      o_tot_nxt  = dist_sum[Q_W:1];
      o_del_nxt  = dist_dif[Q_W:1];
    end
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      radius_r <= RADIUS_RST;
      period_r <= PERIOD_RST;
      rate_l_r <= '0;
      rate_r_r <= '0;
      dist_l_r <= '0;
      dist_r_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      gain_r   <= gain_nxt;
      radius_r <= radius_nxt;
      period_r <= period_nxt;
      rate_l_r <= rate_l_nxt;
      rate_r_r <= rate_r_nxt;
      dist_l_r <= dist_l_nxt;
      dist_r_r <= dist_r_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tick_l_r <= tick_l_nxt;
    tick_r_r <= tick_r_nxt;
    scaled_r <= scaled_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    spd_l_r  <= spd_l_nxt;
    spd_r_r  <= spd_r_nxt;
    o_lspd_r <= o_lspd_nxt;
    o_rspd_r <= o_rspd_nxt;
    o_tot_r  <= o_tot_nxt;
    o_del_r  <= o_del_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_left_speed     = o_lspd_r;
  assign out_right_speed    = o_rspd_r;
  assign out_total_distance = o_tot_r;
  assign out_delta_distance = o_del_r;

endmodule

`default_nettype wire

### design/wheel_odometry_estimator.sv
// An update word runs the update steps for both wheels, a clear word branches to the clear steps.
// A new word is taken only once the sequencer is idle again after the last one; the microprogram
// runs every product through the single 33x17 multiplier and 64-bit accumulator in turn.
// A result waiting on out_ch does not block acceptance; the program stalls at its last step.
// Reset (synchronous, rst_n low): registers take their defaults, rates and distances clear,
// no result pending.
`default_nettype none

module wheel_odometry_estimator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wodo_in_if.sink    in_ch,
  wodo_out_if.source out_ch,
  wodo_cfg_if.sink   cfg_ch
);
  import wodo_pkg::*;

  logic            in_acc;
  logic            cfg_wr;
  logic            out_free;
  logic [PC_W-1:0] pc;
  uword_t          uw;
  ctl_t            ctl;
  seq_status_t     seq_st;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  // Control store
  wodo_ucode_rom u_rom (
    .pc   (pc),
    .word (uw)
  );

  // Step sequencer
  wodo_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_acc),
    .in_opcode (in_ch.opcode),
    .out_free  (out_free),
    .uw        (uw),
    .pc        (pc),
    .in_ready  (in_ch.ready),
    .ctl       (ctl),
    .status    (seq_st)
  );

  // Arithmetic and state
  wodo_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .in_accept          (in_acc),
    .in_left_ticks      (in_ch.left_ticks),
    .in_right_ticks     (in_ch.right_ticks),
    .cfg_write          (cfg_wr),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_left_speed     (out_ch.left_speed),
    .out_right_speed    (out_ch.right_speed),
    .out_total_distance (out_ch.total_distance),
    .out_delta_distance (out_ch.delta_distance),
    .out_free           (out_free)
  );

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while a word was still in progress");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    seq_st.running |-> (seq_st.pc < PROG_LEN))
    else $error("step counter left the microprogram");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(seq_st.running))
    else $error("result word appeared without a program run");

endmodule

`default_nettype wire

### bench/wheel_odometry_estimator_test.sv
// Self-checking bench for the wheel odometry block: tick words against a cycle-free predictor.
`default_nettype none

module wheel_odometry_estimator_test;
  import wodo_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int SEGMENTS     = 4;
  localparam int SEG_WORDS    = 108;

  // Index 3 decodes to no register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Q0.16 smoothing weights of the new sample and of the running rate
  localparam longint SMOOTH_NEW = 6554;
  localparam longint SMOOTH_OLD = 58982;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    logic                     opcode;
    logic signed [TICK_W-1:0] left_ticks;
    logic signed [TICK_W-1:0] right_ticks;
  } tick_word_t;

  typedef struct packed {
    logic signed [Q_W-1:0] left_speed;
    logic signed [Q_W-1:0] right_speed;
    logic signed [Q_W-1:0] total_distance;
    logic signed [Q_W-1:0] delta_distance;
  } odo_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Bench-side drive of the three channels
  logic                 in_valid  = 1'b0;
  tick_word_t           in_word   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;

  wodo_in_if  in_bus();
  wodo_out_if out_bus();
  wodo_cfg_if cfg_bus();

  assign in_bus.valid       = in_valid;
  assign in_bus.opcode      = in_word.opcode;
  assign in_bus.left_ticks  = in_word.left_ticks;
  assign in_bus.right_ticks = in_word.right_ticks;
  assign out_bus.ready      = out_ready;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.index      = cfg_index;
  assign cfg_bus.data       = cfg_data;

  wheel_odometry_estimator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // Predictor copy of the registers and the odometry state
  logic [GAIN_W-1:0]     gain_q   = GAIN_RST;
  logic [RADIUS_W-1:0]   radius_q = RADIUS_RST;
  logic [PERIOD_W-1:0]   period_q = PERIOD_RST;
  logic signed [Q_W-1:0] rate_l   = '0;
  logic signed [Q_W-1:0] rate_r   = '0;
  logic signed [Q_W-1:0] dist_l   = '0;
  logic signed [Q_W-1:0] dist_r   = '0;

  tick_word_t  tick_words[$];
  odo_result_t pending_odometry[$];

  int words_queued = 0;
  int words_taken  = 0;
  int error_count  = 0;
  int cycle_count  = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  function automatic logic signed [Q_W-1:0] sat_q(input longint v);
    if (v > Q_HI) return Q_MAX;
    if (v < Q_LO) return Q_MIN;
    return Q_W'(v);
  endfunction

  // Round half toward plus infinity, then drop s bits
  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [Q_W-1:0] smooth_rate(input logic signed [Q_W-1:0] rate,
                                                       input logic signed [TICK_W-1:0] ticks);
    longint scaled;
    scaled = longint'(ticks) * longint'({32'b0, gain_q});
    return sat_q(round_shr(scaled * SMOOTH_NEW + longint'(rate) * SMOOTH_OLD, 16));
  endfunction

  function automatic logic signed [Q_W-1:0] wheel_speed(input logic signed [Q_W-1:0] rate);
    return sat_q(round_shr(longint'(rate) * longint'({48'b0, radius_q}), 16));
  endfunction

  function automatic logic signed [Q_W-1:0] travel(input logic signed [Q_W-1:0] dist_now,
                                                  input logic signed [Q_W-1:0] speed);
    longint step;
    step = round_shr(longint'(speed) * longint'({40'b0, period_q}), 24);
    return sat_q(longint'(dist_now) + step);
  endfunction

  // Apply one accepted word to the predictor state and return its result
  function automatic odo_result_t advance_odometry(input tick_word_t w);
    odo_result_t res;
    longint      sum;
    longint      diff;
    if (w.opcode == OP_CLEAR) begin
      // ticks ignored, rates kept
      dist_l = '0;
      dist_r = '0;
      res.left_speed  = wheel_speed(rate_l);
      res.right_speed = wheel_speed(rate_r);
    end else begin
      rate_l = smooth_rate(rate_l, w.left_ticks);
      rate_r = smooth_rate(rate_r, w.right_ticks);
      res.left_speed  = wheel_speed(rate_l);
      res.right_speed = wheel_speed(rate_r);
      dist_l = travel(dist_l, res.left_speed);
      dist_r = travel(dist_r, res.right_speed);
    end
    // mean and half difference floor toward minus infinity
    sum  = longint'(dist_l) + longint'(dist_r);
    diff = longint'(dist_l) - longint'(dist_r);
    res.total_distance = Q_W'(sum >>> 1);
    res.delta_distance = Q_W'(diff >>> 1);
    return res;
  endfunction

  // Input driver: holds a word until taken, idles at random between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) begin
        pending_odometry.push_back(advance_odometry(in_word));
        words_taken++;
      end
      if (!in_valid || in_bus.ready) begin
        if (tick_words.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_word  <= tick_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    odo_result_t got;
    odo_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_ready) begin
        got = {out_bus.left_speed, out_bus.right_speed,
               out_bus.total_distance, out_bus.delta_distance};
        if (pending_odometry.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: speed %0d/%0d total %0d delta %0d",
                     got.left_speed, got.right_speed, got.total_distance,
                     got.delta_distance);
        end else begin
          want = pending_odometry.pop_front();
          if (got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
              got.total_distance !== want.total_distance ||
              got.delta_distance !== want.delta_distance) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: left_speed exp %0d got %0d, right_speed exp %0d got %0d",
                       want.left_speed, got.left_speed, want.right_speed, got.right_speed);
              $display("          total exp %0d got %0d, delta exp %0d got %0d",
                       want.total_distance, got.total_distance,
                       want.delta_distance, got.delta_distance);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wheel_odometry_estimator test failed");
      $finish;
    end
  end

  task automatic push_word(input logic op, input int left, input int right);
    tick_word_t w;
    w.opcode      = op;
    w.left_ticks  = TICK_W'(left);
    w.right_ticks = TICK_W'(right);
    tick_words.push_back(w);
    words_queued++;
  endtask

  // Block is idle once every queued word is taken and every result is back
  task automatic drain();
    while (words_taken != words_queued || pending_odometry.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_SPEED_GAIN:     gain_q   = value;
      CFG_WHEEL_RADIUS:   radius_q = value[RADIUS_W-1:0];
      CFG_CONTROL_PERIOD: period_q = value[PERIOD_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [GAIN_W-1:0] gain, input logic [RADIUS_W-1:0] radius,
                           input logic [PERIOD_W-1:0] period);
    write_reg(CFG_SPEED_GAIN, gain);
    write_reg(CFG_WHEEL_RADIUS, GAIN_W'(radius));
    write_reg(CFG_CONTROL_PERIOD, GAIN_W'(period));
  endtask

  // One random register setting followed by a run of random words
  task automatic random_segment(input int n);
    int sel;
    case ($urandom_range(4))
      0: write_all(GAIN_RST, RADIUS_RST, PERIOD_RST);
      1: write_all($urandom, RADIUS_W'($urandom_range(65535)),
                   PERIOD_W'($urandom_range(16777215)));
      2: write_all($urandom_range(1 << 20, 1), RADIUS_W'($urandom_range(65535)),
                   PERIOD_W'($urandom_range(1 << 18, 1)));
      3: write_all(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
      default: write_all($urandom_range(1), RADIUS_W'($urandom_range(1)),
                         PERIOD_W'($urandom_range(1)));
    endcase
    repeat (n) begin
      sel = $urandom_range(15);
      if (sel < 2)
        push_word(OP_CLEAR, $urandom_range(65535), $urandom_range(65535));
      else if (sel < 8)
        push_word(OP_UPDATE, $urandom_range(65535), $urandom_range(65535));
      else if (sel < 14)
        push_word(OP_UPDATE, $urandom_range(512) - 256, $urandom_range(512) - 256);
      else
        push_word(OP_UPDATE, $urandom_range(1) ? 32767 : -32768,
                  $urandom_range(1) ? 32767 : -32768);
    end
    drain();
  endtask

  initial begin
    in_idle_pct  = 17;
    out_idle_pct = 83;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, tick extremes, clear with junk ticks
    push_word(OP_UPDATE, 0, 0);
    push_word(OP_UPDATE, 32767, 32767);
    push_word(OP_UPDATE, -32768, -32768);
    push_word(OP_UPDATE, 32767, -32768);
    push_word(OP_UPDATE, 1, -1);
    push_word(OP_CLEAR, 'h5A5A, 'hA5A5);
    push_word(OP_UPDATE, -1, 1);
    drain();

    // Write to an unused index, then zero gain
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_SPEED_GAIN, '0);
    push_word(OP_UPDATE, 500, -500);
    push_word(OP_CLEAR, 'hFFFF, 'h0000);
    drain();

    // Largest settings: rates and distances run into saturation both ways
    write_all(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
    repeat (3) push_word(OP_UPDATE, 32767, -32768);
    push_word(OP_CLEAR, 0, 0);
    repeat (2) push_word(OP_UPDATE, -32768, 32767);
    drain();

    // Smallest settings
    write_all(32'd1, 16'd0, 24'd0);
    push_word(OP_UPDATE, 32767, -32768);
    push_word(OP_UPDATE, 0, 0);
    drain();

    // Random phases: slow receiver, then slow sender, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 83 : 0;
      out_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 17 : 0;
      repeat (SEGMENTS) random_segment(SEG_WORDS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_odometry.size() == 0) begin
      $display("wheel_odometry_estimator test passed");
    end else begin
      $display("wheel_odometry_estimator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
